>>> rtl/cdp_pkg.sv
`default_nettype none
package cdp_pkg;

   localparam int unsigned TailCap   = 40;
   localparam int unsigned TailBits  = TailCap * 8;

   localparam logic [1:0] PH_LEN   = 2'd0;
   localparam logic [1:0] PH_SIZE  = 2'd1;
   localparam logic [1:0] PH_FIRST = 2'd2;
   localparam logic [1:0] PH_TAIL  = 2'd3;

   localparam logic [2:0] ST_RECORD      = 3'd0;
   localparam logic [2:0] ST_SUMMARY_OK  = 3'd1;
   localparam logic [2:0] ST_SUMMARY_UNP = 3'd2;
   localparam logic [2:0] ST_ZERO_BLOCK  = 3'd3;
   localparam logic [2:0] ST_FIRST_RANGE = 3'd4;
   localparam logic [2:0] ST_TAIL_RANGE  = 3'd5;
   localparam logic [2:0] ST_SIZE_MISM   = 3'd6;

   localparam logic CSR_BLOCK_SIZE  = 1'b0;
   localparam logic CSR_BLOCK_COUNT = 1'b1;

   typedef struct packed {
      logic step;
      logic div_start;
      logic div_run;
      logic tail_setup;
      logic rec_done;
      logic sum_done;
      logic sum_sel;
   } cmd_type;

   typedef struct packed {
      logic start_tail;
      logic emit;
      logic last;
      logic div_done;
   } stat_type;

   typedef struct packed {
      logic [63:0] chunk_length;
      logic [63:0] first_block;
      logic [63:0] tail_check;
      logic [63:0] tail_hash_low;
      logic [63:0] tail_hash_high;
      logic [63:0] tail_blk;
      logic [63:0] tail_pos;
      logic [63:0] total_size;
      logic [31:0] chunk_total;
      logic [2:0]  status;
      logic        last_of_run;
   } rsp_payload_type;

endpackage
`default_nettype wire

>>> rtl/cdp_if.sv
`default_nettype none
interface cdp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cdp_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] chunk_length;
   logic [63:0] first_block;
   logic [63:0] tail_check;
   logic [63:0] tail_hash_low;
   logic [63:0] tail_hash_high;
   logic [63:0] tail_blk;
   logic [63:0] tail_pos;
   logic [63:0] total_size;
   logic [31:0] chunk_total;
   logic [2:0]  status;
   logic        last_of_run;
   modport source (output valid, output chunk_length, output first_block, output tail_check,
                   output tail_hash_low, output tail_hash_high, output tail_blk,
                   output tail_pos, output total_size, output chunk_total,
                   output status, output last_of_run, input ready);
   modport sink (input valid, input chunk_length, input first_block, input tail_check,
                 input tail_hash_low, input tail_hash_high, input tail_blk,
                 input tail_pos, input total_size, input chunk_total,
                 input status, input last_of_run, output ready);
endinterface
`default_nettype wire

>>> rtl/chunk_description_parser_top.sv
// Chunk-description parser: takes one byte per request and returns decoded
// chunk records plus a summary at the byte marked last. A byte passes through
// accept, evaluate and finish steps; a byte that closes a length or
// first-block field leading into a tail also runs the bit-serial
// remainder unit that computes length mod block size. Each result is held
// on the response side until it is taken. Registers may be written only
// while no request is in flight.
`default_nettype none
module chunk_description_parser_top
   import cdp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   cdp_req_if.sink          req_chan,
   cdp_rsp_if.source        rsp_chan,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [63:0] csr_write_data
);
   cmd_type         cmd;
   stat_type        stat;
   rsp_payload_type payload;

   cdp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cdp_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .data_byte        (req_chan.data_byte),
      .last_byte        (req_chan.last_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .payload          (payload)
   );

   assign rsp_chan.chunk_length   = payload.chunk_length;
   assign rsp_chan.first_block    = payload.first_block;
   assign rsp_chan.tail_check     = payload.tail_check;
   assign rsp_chan.tail_hash_low  = payload.tail_hash_low;
   assign rsp_chan.tail_hash_high = payload.tail_hash_high;
   assign rsp_chan.tail_blk       = payload.tail_blk;
   assign rsp_chan.tail_pos       = payload.tail_pos;
   assign rsp_chan.total_size     = payload.total_size;
   assign rsp_chan.chunk_total    = payload.chunk_total;
   assign rsp_chan.status         = payload.status;
   assign rsp_chan.last_of_run    = payload.last_of_run;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request taken while a response is pending");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted back to back");

   a_record_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.status == ST_RECORD
       && !rsp_chan.last_of_run) |=> (rsp_chan.valid && rsp_chan.status != ST_RECORD))
      else $error("summary does not follow record on last byte");
endmodule
`default_nettype wire

>>> rtl/cdp_div.sv
`default_nettype none
module cdp_div
   import cdp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        run,
   input  wire logic [63:0] dividend,
   input  wire logic [63:0] divisor,
   output logic      [63:0] remainder,
   output logic             done
);
   logic [63:0] rem_ff, rem_in;
   logic [63:0] dvd_ff, dvd_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [64:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      cnt_in  = cnt_ff;
      done_in = done_ff;
      trial   = {rem_ff, dvd_ff[63]};
      if (start) begin
         rem_in  = '0;
         dvd_in  = dividend;
         cnt_in  = '1;
         done_in = 1'b0;
      end else if (run && !done_ff) begin
         dvd_in = {dvd_ff[62:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = 64'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[63:0];
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == '0) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   assign remainder = rem_ff;
   assign done      = done_ff;
endmodule
`default_nettype wire

>>> rtl/cdp_dp.sv
`default_nettype none
module cdp_dp
   import cdp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire cmd_type         cmd,
   output stat_type             stat,
   input  wire logic [7:0]      data_byte,
   input  wire logic            last_byte,
   input  wire logic            csr_write_enable,
   input  wire logic            csr_index,
   input  wire logic [63:0]     csr_write_data,
   output rsp_payload_type      payload
);
   logic [1:0]          phase_ff, phase_in;
   logic [5:0]          bi_ff, bi_in;
   logic [5:0]          tb_ff, tb_in;
   logic [63:0]         len_ff, len_in;
   logic [63:0]         blk_ff, blk_in;
   logic [63:0]         sum_ff, sum_in;
   logic [TailBits-1:0] tail_ff, tail_in;
   logic [31:0]         cnt_ff, cnt_in;
   logic                unprot_ff, unprot_in;
   logic                err_ff, err_in;
   logic [2:0]          code_ff, code_in;
   logic                evt_ff, evt_in;
   logic                eve_ff, eve_in;
   logic                last_ff, last_in;
   logic [63:0]         bs_ff, bc_ff;
   logic [5:0]          nbi;
   logic [63:0]         rem;
   logic                div_done;
   logic [2:0]          sum_status;

   cdp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .run       (cmd.div_run),
      .dividend  (len_ff),
      .divisor   (bs_ff),
      .remainder (rem),
      .done      (div_done)
   );

   always_comb begin
      phase_in  = phase_ff;
      bi_in     = bi_ff;
      tb_in     = tb_ff;
      len_in    = len_ff;
      blk_in    = blk_ff;
      sum_in    = sum_ff;
      tail_in   = tail_ff;
      cnt_in    = cnt_ff;
      unprot_in = unprot_ff;
      err_in    = err_ff;
      code_in   = code_ff;
      evt_in    = evt_ff;
      eve_in    = eve_ff;
      last_in   = last_ff;
      nbi       = bi_ff + 6'd1;
      if (cmd.step) begin
         last_in = last_byte;
         evt_in  = 1'b0;
         eve_in  = 1'b0;
         if (!err_ff) begin
            bi_in = nbi;
            case (phase_ff)
               PH_LEN: begin
                  if (bi_ff == '0) begin
                     len_in = {56'd0, data_byte};
                  end else begin
                     for (int k = 0; k < 8; k++) begin
                        if (bi_ff[2:0] == 3'(k)) begin
                           len_in[8*k +: 8] = data_byte;
                        end
                     end
                  end
                  if (nbi >= 6'd8) begin
                     bi_in  = '0;
                     blk_in = '0;
                     if (len_in == '0) begin
                        unprot_in = 1'b1;
                        phase_in  = PH_SIZE;
                     end else if (bs_ff == '0) begin
                        err_in  = 1'b1;
                        code_in = ST_ZERO_BLOCK;
                     end else begin
                        sum_in = sum_ff + len_in;
                        if (len_in >= bs_ff) begin
                           phase_in = PH_FIRST;
                        end else begin
                           evt_in = 1'b1;
                        end
                     end
                  end
               end
               PH_SIZE, PH_FIRST: begin
                  for (int k = 0; k < 8; k++) begin
                     if (bi_ff[2:0] == 3'(k)) begin
                        blk_in[8*k +: 8] = data_byte;
                     end
                  end
                  if (nbi >= 6'd8) begin
                     if (phase_ff == PH_SIZE) begin
                        sum_in   = sum_ff + blk_in;
                        eve_in   = 1'b1;
                        phase_in = PH_LEN;
                        bi_in    = '0;
                     end else if (blk_in >= bc_ff) begin
                        err_in  = 1'b1;
                        code_in = ST_FIRST_RANGE;
                     end else begin
                        evt_in = 1'b1;
                     end
                  end
               end
               default: begin
                  for (int i = 0; i < TailCap; i++) begin
                     if (bi_ff == 6'(i)) begin
                        tail_in[8*i +: 8] = data_byte;
                     end
                  end
                  if (nbi >= tb_ff) begin
                     if (tb_ff >= 6'(TailCap) && tail_ff[255:192] >= bc_ff) begin
                        err_in  = 1'b1;
                        code_in = ST_TAIL_RANGE;
                     end else begin
                        eve_in   = 1'b1;
                        phase_in = PH_LEN;
                        bi_in    = '0;
                     end
                  end
               end
            endcase
         end
      end
      if (cmd.tail_setup) begin
         evt_in  = 1'b0;
         tail_in = '0;
         bi_in   = '0;
         tb_in   = (rem >= 64'(TailCap)) ? 6'(TailCap) : rem[5:0];
         if (tb_in == '0) begin
            eve_in   = 1'b1;
            phase_in = PH_LEN;
         end else begin
            phase_in = PH_TAIL;
         end
      end
      if (cmd.rec_done) begin
         eve_in = 1'b0;
         if (cnt_ff != '1) begin
            cnt_in = cnt_ff + 32'd1;
         end
      end
      if (cmd.sum_done) begin
         phase_in  = PH_LEN;
         bi_in     = '0;
         tb_in     = '0;
         len_in    = '0;
         blk_in    = '0;
         sum_in    = '0;
         cnt_in    = '0;
         unprot_in = 1'b0;
         err_in    = 1'b0;
         code_in   = '0;
         evt_in    = 1'b0;
         eve_in    = 1'b0;
         last_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      tail_ff <= tail_in;
      if (reset) begin
         phase_ff  <= PH_LEN;
         bi_ff     <= '0;
         tb_ff     <= '0;
         len_ff    <= '0;
         blk_ff    <= '0;
         sum_ff    <= '0;
         cnt_ff    <= '0;
         unprot_ff <= 1'b0;
         err_ff    <= 1'b0;
         code_ff   <= '0;
         evt_ff    <= 1'b0;
         eve_ff    <= 1'b0;
         last_ff   <= 1'b0;
         bs_ff     <= '0;
         bc_ff     <= '0;
      end else begin
         phase_ff  <= phase_in;
         bi_ff     <= bi_in;
         tb_ff     <= tb_in;
         len_ff    <= len_in;
         blk_ff    <= blk_in;
         sum_ff    <= sum_in;
         cnt_ff    <= cnt_in;
         unprot_ff <= unprot_in;
         err_ff    <= err_in;
         code_ff   <= code_in;
         evt_ff    <= evt_in;
         eve_ff    <= eve_in;
         last_ff   <= last_in;
         if (csr_write_enable && csr_index == CSR_BLOCK_SIZE) begin
            bs_ff <= csr_write_data;
         end
         if (csr_write_enable && csr_index == CSR_BLOCK_COUNT) begin
            bc_ff <= csr_write_data;
         end
      end
   end

   assign stat.start_tail = evt_ff;
   assign stat.emit       = eve_ff;
   assign stat.last       = last_ff;
   assign stat.div_done   = div_done;

   always_comb begin
      if (err_ff) begin
         sum_status = code_ff;
      end else if (phase_ff != PH_LEN || bi_ff != '0) begin
         sum_status = ST_SIZE_MISM;
      end else if (unprot_ff) begin
         sum_status = ST_SUMMARY_UNP;
      end else begin
         sum_status = ST_SUMMARY_OK;
      end
      payload = '0;
      if (cmd.sum_sel) begin
         payload.status      = sum_status;
         payload.last_of_run = 1'b1;
         if (!err_ff) begin
            payload.total_size  = sum_ff;
            payload.chunk_total = cnt_ff;
         end
      end else begin
         payload.chunk_length = len_ff;
         payload.first_block  = blk_ff;
         payload.status       = ST_RECORD;
         payload.last_of_run  = !last_ff;
         if (len_ff != '0) begin
            payload.tail_check     = tail_ff[63:0];
            payload.tail_hash_low  = tail_ff[127:64];
            payload.tail_hash_high = tail_ff[191:128];
            payload.tail_blk       = tail_ff[255:192];
            payload.tail_pos       = tail_ff[319:256];
         end
      end
   end
endmodule
`default_nettype wire

>>> rtl/cdp_ctrl.sv
`default_nettype none
module cdp_ctrl
   import cdp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EVAL = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_FIN  = 3'd3;
   localparam logic [2:0] S_REC  = 3'd4;
   localparam logic [2:0] S_SUM  = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.step = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (stat.start_tail) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_FIN;
            end
         end
         S_DIV: begin
            if (stat.div_done) begin
               cmd.tail_setup = 1'b1;
               state_in       = S_FIN;
            end else begin
               cmd.div_run = 1'b1;
            end
         end
         S_FIN: begin
            if (stat.emit) begin
               state_in = S_REC;
            end else if (stat.last) begin
               state_in = S_SUM;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_REC: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.rec_done = 1'b1;
               state_in     = stat.last ? S_SUM : S_IDLE;
            end
         end
         S_SUM: begin
            rsp_valid   = 1'b1;
            cmd.sum_sel = 1'b1;
            if (rsp_ready) begin
               cmd.sum_done = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire
